// File: hdl/stb_pkg.sv
// package for the software timer bank
// beat types, command codes, memory entry type and the remaining-ticks helper
// no dependencies
package stb_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_EXPIRIES   = 16;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_INIT   = 3'd1;
	localparam logic [2:0] CMD_START  = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_PERIOD = 3'd4;
	localparam logic [2:0] CMD_QUERY  = 3'd5;

	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  timer_id;
		logic [31:0] period_value;
		logic        reload_mode;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  result_timer;
		logic        running;
		logic [31:0] period_out;
		logic [30:0] remaining;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] expiry;
		logic [31:0] period;
	} entry_t;

	function automatic logic [30:0] remaining_of(logic run, logic [31:0] expiry,
			logic [31:0] now);
		logic [31:0] d;
		d = expiry - now;
		if (!run || d == 32'd0 || d[31])
			return 31'd0;
		return d[30:0];
	endfunction

endpackage

// File: hdl/stb_store.sv
// timer entry store: expiry tick and period per timer, one read and one write port
// unwritten entries read back with the reset period of one
// depends on stb_pkg
module stb_store #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
	parameter int IW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output stb_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  stb_pkg::entry_t wr_data
);
	import stb_pkg::*;

	entry_t mem [NUM_TIMERS];
	entry_t rd_q;
	logic [NUM_TIMERS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_comb begin
		rd_data = rd_q;
		if (!rd_vld_q)
			rd_data.period = 32'd1;
	end

endmodule

// File: hdl/software_timer_bank.sv
// software timer bank top level: command sequencer, expiry scan and result register
// depends on stb_pkg and stb_store
//
//  channel | signals               | handshake
//  item    | start, busy, item     | taken when start high and busy low
//  result  | strobe, result        | one cycle per beat, no back-pressure
//
// a command reads its entry from the store, then writes it back and replies
// a tick handles up to MAX_EXPIRIES expiries: each expiry is one full scan of
// the store through its single read port, then a write back if the timer reloads
// a tick with nothing due is a single scan of the store
// reset clears the counter and all run flags; the store needs no clearing pass
// results cannot be held off, so busy depends on the sequencer alone
module software_timer_bank #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  stb_pkg::item_t   item,
	output logic             strobe,
	output stb_pkg::result_t result
);
	import stb_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int FW = $clog2(MAX_EXPIRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CEX, S_SCAN, S_SEND, S_DEC, S_FIRE, S_FLUSH
	} state_t;

	state_t state_q;
	logic [31:0] now_q;
	logic [NUM_TIMERS-1:0] run_q, ar_q, fired_q;
	logic [IW-1:0] scan_q, idx_s1, best_q;
	logic v_s1, found_q;
	logic [31:0] bkey_q, bper_q;
	logic [FW-1:0] fcnt_q;
	item_t cmd_q;
	result_t pend_q, result_q;
	logic pend_v_q, strobe_q;

	logic accept, id_ok;
	logic [XW:0] id_ext;
	logic [IW-1:0] id_idx, cmd_idx;
	logic rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	entry_t rd_data, wr_data;

	logic [31:0] per_in, n_per, n_exp, key, d_scan, fire_exp;
	logic n_run, n_ar, cand;
	logic [30:0] fire_rem;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign id_ext  = (XW+1)'(item.timer_id);
	assign id_idx  = id_ext[IW-1:0];
	assign id_ok   = id_ext < (XW+1)'(NUM_TIMERS);
	assign cmd_idx = IW'(cmd_q.timer_id);
	assign strobe  = strobe_q;
	assign result  = result_q;

	assign rd_en   = (accept && item.command != CMD_TICK && id_ok) || state_q == S_SCAN;
	assign rd_addr = (state_q == S_SCAN) ? scan_q : id_idx;

	// command execution on the entry just read
	always_comb begin
		per_in = (cmd_q.period_value == 32'd0) ? 32'd1 : cmd_q.period_value;
		n_per  = rd_data.period;
		n_exp  = rd_data.expiry;
		n_run  = run_q[cmd_idx];
		n_ar   = ar_q[cmd_idx];
		case (cmd_q.command)
			CMD_INIT: begin
				n_per = per_in;
				n_ar  = cmd_q.reload_mode;
				n_run = 1'b0;
				n_exp = 32'd0;
			end
			CMD_START: begin
				n_exp = now_q + rd_data.period;
				n_run = 1'b1;
			end
			CMD_STOP: n_run = 1'b0;
			CMD_PERIOD: begin
				n_per = per_in;
				if (n_run)
					n_exp = now_q + per_in;
			end
			default: ;
		endcase
	end

	// scan compare and rearm of the chosen timer
	assign d_scan   = rd_data.expiry - now_q;
	assign key      = d_scan ^ 32'h8000_0000;
	assign cand     = v_s1 && run_q[idx_s1] && !fired_q[idx_s1]
		&& (d_scan == 32'd0 || d_scan[31]);
	assign fire_exp = now_q + bper_q;
	assign fire_rem = bper_q[31] ? 31'd0 : bper_q[30:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_data = '{expiry: fire_exp, period: bper_q};
		if (state_q == S_CEX) begin
			wr_en   = 1'b1;
			wr_addr = cmd_idx;
			wr_data = '{expiry: n_exp, period: n_per};
		end else if (state_q == S_FIRE && ar_q[best_q]) begin
			wr_en = 1'b1;
		end
	end

	stb_store #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept)
			cmd_q <= item;
		if (cand && (!found_q || key < bkey_q)) begin
			best_q <= idx_s1;
			bkey_q <= key;
			bper_q <= rd_data.period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			now_q    <= '0;
			run_q    <= '0;
			ar_q     <= '0;
			fired_q  <= '0;
			scan_q   <= '0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			fcnt_q   <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			v_s1     <= (state_q == S_SCAN);
			if (cand && (!found_q || key < bkey_q))
				found_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.command == CMD_TICK) begin
							now_q    <= now_q + 32'd1;
							fired_q  <= '0;
							fcnt_q   <= '0;
							scan_q   <= '0;
							found_q  <= 1'b0;
							pend_v_q <= 1'b0;
							state_q  <= S_SCAN;
						end else if (!id_ok) begin
							strobe_q <= 1'b1;
							result_q <= '{kind: KIND_REPLY, result_timer: item.timer_id,
								running: 1'b0, period_out: 32'd0, remaining: 31'd0,
								last: 1'b1};
						end else begin
							state_q <= S_CEX;
						end
					end
				end
				S_CEX: begin
					run_q[cmd_idx] <= n_run;
					ar_q[cmd_idx]  <= n_ar;
					strobe_q <= 1'b1;
					result_q <= '{kind: KIND_REPLY, result_timer: cmd_q.timer_id,
						running: n_run, period_out: n_per,
						remaining: remaining_of(n_run, n_exp, now_q), last: 1'b1};
					state_q  <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_q == IW'(NUM_TIMERS - 1))
						state_q <= S_SEND;
					else
						scan_q <= scan_q + 1'b1;
				end
				S_SEND: state_q <= S_DEC;
				S_DEC: begin
					if (pend_v_q) begin
						strobe_q <= 1'b1;
						result_q <= '{kind: pend_q.kind, result_timer: pend_q.result_timer,
							running: pend_q.running, period_out: pend_q.period_out,
							remaining: pend_q.remaining, last: !found_q};
					end
					pend_v_q <= 1'b0;
					state_q  <= found_q ? S_FIRE : S_IDLE;
				end
				S_FIRE: begin
					fired_q[best_q] <= 1'b1;
					if (!ar_q[best_q])
						run_q[best_q] <= 1'b0;
					pend_q <= '{kind: KIND_EXPIRY, result_timer: 4'(best_q),
						running: ar_q[best_q], period_out: bper_q,
						remaining: ar_q[best_q] ? fire_rem : 31'd0, last: 1'b0};
					pend_v_q <= 1'b1;
					fcnt_q   <= fcnt_q + 1'b1;
					scan_q   <= '0;
					found_q  <= 1'b0;
					if (fcnt_q + 1'b1 == FW'(MAX_EXPIRIES))
						state_q <= S_FLUSH;
					else
						state_q <= S_SCAN;
				end
				S_FLUSH: begin
					strobe_q <= 1'b1;
					result_q <= '{kind: pend_q.kind, result_timer: pend_q.result_timer,
						running: pend_q.running, period_out: pend_q.period_out,
						remaining: pend_q.remaining, last: 1'b1};
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FW'(MAX_EXPIRIES))
		else $error("expiry count beyond limit");

	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.kind == KIND_REPLY |-> result_q.last)
		else $error("command reply without last");

	a_oneshot_rem: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.running |-> result_q.remaining == 31'd0)
		else $error("stopped timer with remaining ticks");

	a_cmd_reply: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CEX |=> strobe_q && state_q == S_IDLE)
		else $error("command without reply");

	a_fire_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> $past(found_q))
		else $error("fire without a due timer");

endmodule
